// ===== rtl/core/rtp_meta_info_field_parser_defines.svh =====
// Assertion macros shared by the result buffer and the per-byte parser.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef RTP_META_INFO_FIELD_PARSER_DEFINES_SVH
`define RTP_META_INFO_FIELD_PARSER_DEFINES_SVH

// Whenever ante holds, cons holds in the same cycle.
`define RMIFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds, cons holds in the next cycle.
`define RMIFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The condition never holds.
`define RMIFP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/rmifp_pkg.sv =====
// ----------------------------------------------------------------------------
// rmifp_pkg
// Types, constants and lookup tables of the RTP meta-info field parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rmifp_pkg;

  localparam int NUM_ID_REGS         = 6;
  localparam int DEF_NUM_FIELD_KINDS = 6;
  localparam int DEF_HEADER_BYTES    = 12;
  localparam int CFG_ADDR_W          = 5;
  localparam int CFG_DATA_W          = 32;

  localparam logic [7:0]  ID_UNUSED   = 8'd128;
  localparam logic [15:0] NAME_UNUSED = 16'h8000;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_ID_PACKET_POSITION = 3'd0;
  localparam logic [2:0] REG_ID_TRANSMIT_TIME   = 3'd1;
  localparam logic [2:0] REG_ID_FRAME_TYPE      = 3'd2;
  localparam logic [2:0] REG_ID_PACKET_NUMBER   = 3'd3;
  localparam logic [2:0] REG_ID_SEQUENCE_NUMBER = 3'd4;
  localparam logic [2:0] REG_ID_MEDIA_DATA      = 3'd5;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_START   = 3'd1,
    PH_CLEN    = 3'd2,
    PH_NAME_LO = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_LEN_LO  = 3'd5,
    PH_VALUE   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    FK_POSITION   = 3'd0,
    FK_XMIT_TIME  = 3'd1,
    FK_FRAME_TYPE = 3'd2,
    FK_PACKET_NUM = 3'd3,
    FK_SEQUENCE   = 3'd4,
    FK_MEDIA      = 3'd5,
    FK_ILLEGAL    = 3'd7
  } field_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic        last_byte;
  } in_t;

  typedef struct packed {
    logic        packet_ok;
    logic [63:0] packet_position;
    logic [63:0] transmit_time;
    logic [15:0] frame_type;
    logic [63:0] packet_number;
    logic [15:0] sequence_number;
    logic [15:0] media_offset;
    logic [15:0] media_length;
  } out_t;

  // Two-character names of the uncompressed field forms.
  function automatic logic [15:0] kind_name(input field_t f);
    logic [15:0] n;
    case (f)
      FK_POSITION:   n = 16'h7070;  // "pp"
      FK_XMIT_TIME:  n = 16'h7474;  // "tt"
      FK_FRAME_TYPE: n = 16'h6674;  // "ft"
      FK_PACKET_NUM: n = 16'h706E;  // "pn"
      FK_SEQUENCE:   n = 16'h7371;  // "sq"
      FK_MEDIA:      n = 16'h6D64;  // "md"
      default:       n = NAME_UNUSED;
    endcase
    return n;
  endfunction

  // Required value length of each kind; zero means any length is allowed.
  function automatic logic [15:0] kind_len(input field_t f);
    logic [15:0] l;
    case (f)
      FK_POSITION:   l = 16'd8;
      FK_XMIT_TIME:  l = 16'd8;
      FK_FRAME_TYPE: l = 16'd2;
      FK_PACKET_NUM: l = 16'd8;
      FK_SEQUENCE:   l = 16'd2;
      default:       l = 16'd0;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rmifp_out_buf.sv =====
// ----------------------------------------------------------------------------
// rmifp_out_buf
// Two-word result buffer; the head word drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtp_meta_info_field_parser_defines.svh"

module rmifp_out_buf import rmifp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire out_t din,
  output logic      full,
  output logic      result_valid,
  input  wire logic result_stall,
  output out_t      result_data
);

  logic [1:0] count;
  out_t       slot0;
  out_t       slot1;
  logic       pop;

  assign pop          = (count != 2'd0) && !result_stall;
  assign full         = (count == 2'd2);
  assign result_valid = (count != 2'd0);
  assign result_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Slot 0 always holds the oldest word.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        slot0 <= din;
      end else begin
        slot0 <= slot1;
      end
      if (push && count == 2'd2) begin
        slot1 <= din;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

  `RMIFP_ASSERT_NEVER(a_no_overflow, push && count == 2'd2, "result buffer overflow")
  `RMIFP_ASSERT_NEVER(a_count_range, count == 2'd3, "result buffer count out of range")
  `RMIFP_ASSERT_NXT(a_drain, pop && !push && count == 2'd1, count == 2'd0, "buffer did not drain")

endmodule

`default_nettype wire

// ===== rtl/core/rmifp_parser.sv =====
// ----------------------------------------------------------------------------
// rmifp_parser
// Per-byte field parser: packet state, stored values and the result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtp_meta_info_field_parser_defines.svh"

module rmifp_parser import rmifp_pkg::*; #(
  parameter int NUM_FIELD_KINDS = DEF_NUM_FIELD_KINDS,
  parameter int HEADER_BYTES    = DEF_HEADER_BYTES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         take,
  input  wire in_t                          item,
  input  wire logic [NUM_ID_REGS-1:0][7:0]  cfg_ids,
  output out_t                              result
);

  logic [15:0] byte_position, byte_position_next;
  phase_t      parse_phase, parse_phase_next;
  field_t      current_field, current_field_next;
  logic [15:0] field_length, field_length_next;
  logic [15:0] bytes_left_in_field, bytes_left_in_field_next;
  logic [63:0] value_accumulator, value_accumulator_next;
  logic [7:0]  name_high_byte, name_high_byte_next;
  logic        parse_ended, parse_ended_next;
  logic        parse_failed, parse_failed_next;
  logic [63:0] stored_position, stored_position_next;
  logic [63:0] stored_transmit_time, stored_transmit_time_next;
  logic [15:0] stored_frame_type, stored_frame_type_next;
  logic [63:0] stored_packet_number, stored_packet_number_next;
  logic [15:0] stored_sequence, stored_sequence_next;
  logic [15:0] stored_media_offset, stored_media_offset_next;
  logic [15:0] stored_media_length, stored_media_length_next;

  phase_t      ph;
  logic        hdr;
  logic [15:0] need;
  logic [16:0] vpos;
  logic [17:0] vend;
  logic [15:0] left_dec;

  // First match in register order wins. Kinds beyond the six registers
  // have no register and no name, so they never match.
  function automatic field_t id_lookup(input logic [NUM_ID_REGS-1:0][7:0] ids,
                                       input logic [6:0] id);
    field_t f;
    f = FK_ILLEGAL;
    for (int k = NUM_ID_REGS - 1; k >= 0; k--) begin
      if (k < NUM_FIELD_KINDS && ids[k] == {1'b0, id}) begin
        f = field_t'(k[2:0]);
      end
    end
    return f;
  endfunction

  function automatic field_t name_lookup(input logic [15:0] name);
    field_t f;
    f = FK_ILLEGAL;
    for (int k = NUM_ID_REGS - 1; k >= 0; k--) begin
      if (k < NUM_FIELD_KINDS && kind_name(field_t'(k[2:0])) == name) begin
        f = field_t'(k[2:0]);
      end
    end
    return f;
  endfunction

  always_comb begin
    byte_position_next        = byte_position;
    parse_phase_next          = parse_phase;
    current_field_next        = current_field;
    field_length_next         = field_length;
    bytes_left_in_field_next  = bytes_left_in_field;
    value_accumulator_next    = value_accumulator;
    name_high_byte_next       = name_high_byte;
    parse_ended_next          = parse_ended;
    parse_failed_next         = parse_failed;
    stored_position_next      = stored_position;
    stored_transmit_time_next = stored_transmit_time;
    stored_frame_type_next    = stored_frame_type;
    stored_packet_number_next = stored_packet_number;
    stored_sequence_next      = stored_sequence;
    stored_media_offset_next  = stored_media_offset;
    stored_media_length_next  = stored_media_length;
    ph       = parse_phase;
    hdr      = 1'b0;
    need     = 16'd0;
    vend     = 18'd0;
    left_dec = 16'd0;
    // The value of a field whose header ends on this byte starts at the next.
    vpos     = {1'b0, byte_position} + 17'd1;

    if (take) begin
      if (!parse_ended) begin
        if (parse_phase == PH_HEADER && byte_position >= 16'(HEADER_BYTES)) begin
          ph               = PH_START;
          parse_phase_next = PH_START;
        end
        case (ph)
          PH_HEADER: begin
          end
          PH_START: begin
            if ({1'b0, byte_position} + 17'd2 >= {1'b0, item.packet_length}) begin
              parse_ended_next = 1'b1;
            end else if (item.data_byte[7]) begin
              current_field_next = id_lookup(cfg_ids, item.data_byte[6:0]);
              parse_phase_next   = PH_CLEN;
            end else if ({1'b0, byte_position} + 17'd4 >= {1'b0, item.packet_length}) begin
              parse_ended_next = 1'b1;
            end else begin
              name_high_byte_next = item.data_byte;
              parse_phase_next    = PH_NAME_LO;
            end
          end
          PH_CLEN: begin
            field_length_next = {8'h00, item.data_byte};
            hdr               = 1'b1;
          end
          PH_NAME_LO: begin
            current_field_next = name_lookup({name_high_byte, item.data_byte});
            parse_phase_next   = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            field_length_next = {item.data_byte, 8'h00};
            parse_phase_next  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            field_length_next = field_length | {8'h00, item.data_byte};
            hdr               = 1'b1;
          end
          PH_VALUE: begin
            value_accumulator_next = {value_accumulator[55:0], item.data_byte};
            left_dec = (bytes_left_in_field != 16'd0) ? bytes_left_in_field - 16'd1
                                                      : bytes_left_in_field;
            bytes_left_in_field_next = left_dec;
            if (left_dec == 16'd0) begin
              case (current_field)
                FK_POSITION:   stored_position_next      = value_accumulator_next;
                FK_XMIT_TIME:  stored_transmit_time_next = value_accumulator_next;
                FK_FRAME_TYPE: stored_frame_type_next    = value_accumulator_next[15:0];
                FK_PACKET_NUM: stored_packet_number_next = value_accumulator_next;
                FK_SEQUENCE:   stored_sequence_next      = value_accumulator_next[15:0];
                default: begin
                end
              endcase
              parse_phase_next = PH_START;
            end
          end
          default: begin
            parse_ended_next = 1'b1;
          end
        endcase

        // Header complete: length check, bound check, then the value starts.
        if (hdr) begin
          need = kind_len(current_field);
          vend = {1'b0, vpos} + {2'b00, field_length_next};
          if (need != 16'd0 && need != field_length_next) begin
            parse_failed_next = 1'b1;
            parse_ended_next  = 1'b1;
          end else if (vend > {2'b00, item.packet_length}) begin
            parse_failed_next = 1'b1;
            parse_ended_next  = 1'b1;
          end else begin
            if (current_field == FK_MEDIA) begin
              stored_media_offset_next = vpos[15:0];
              stored_media_length_next = field_length_next;
            end
            bytes_left_in_field_next = field_length_next;
            value_accumulator_next   = 64'd0;
            parse_phase_next = (field_length_next == 16'd0) ? PH_START : PH_VALUE;
          end
        end
      end

      if (byte_position != 16'hFFFF) begin
        byte_position_next = byte_position + 16'd1;
      end
    end

    result.packet_ok       = !parse_failed_next;
    result.packet_position = stored_position_next;
    result.transmit_time   = stored_transmit_time_next;
    result.frame_type      = stored_frame_type_next;
    result.packet_number   = stored_packet_number_next;
    result.sequence_number = stored_sequence_next;
    result.media_offset    = stored_media_offset_next;
    result.media_length    = stored_media_length_next;

    // The last byte closes the packet; stored values are kept.
    if (take && item.last_byte) begin
      byte_position_next       = 16'd0;
      parse_phase_next         = PH_HEADER;
      current_field_next       = FK_ILLEGAL;
      field_length_next        = 16'd0;
      bytes_left_in_field_next = 16'd0;
      value_accumulator_next   = 64'd0;
      name_high_byte_next      = 8'd0;
      parse_ended_next         = 1'b0;
      parse_failed_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= 16'd0;
      parse_phase          <= PH_HEADER;
      current_field        <= FK_ILLEGAL;
      field_length         <= 16'd0;
      bytes_left_in_field  <= 16'd0;
      value_accumulator    <= 64'd0;
      name_high_byte       <= 8'd0;
      parse_ended          <= 1'b0;
      parse_failed         <= 1'b0;
      stored_position      <= 64'd0;
      stored_transmit_time <= 64'd0;
      stored_frame_type    <= 16'd0;
      stored_packet_number <= 64'd0;
      stored_sequence      <= 16'd0;
      stored_media_offset  <= 16'd0;
      stored_media_length  <= 16'd0;
    end else begin
      byte_position        <= byte_position_next;
      parse_phase          <= parse_phase_next;
      current_field        <= current_field_next;
      field_length         <= field_length_next;
      bytes_left_in_field  <= bytes_left_in_field_next;
      value_accumulator    <= value_accumulator_next;
      name_high_byte       <= name_high_byte_next;
      parse_ended          <= parse_ended_next;
      parse_failed         <= parse_failed_next;
      stored_position      <= stored_position_next;
      stored_transmit_time <= stored_transmit_time_next;
      stored_frame_type    <= stored_frame_type_next;
      stored_packet_number <= stored_packet_number_next;
      stored_sequence      <= stored_sequence_next;
      stored_media_offset  <= stored_media_offset_next;
      stored_media_length  <= stored_media_length_next;
    end
  end

  `RMIFP_ASSERT_IMP(a_fail_ends, parse_failed, parse_ended, "failed packet not ended")
  `RMIFP_ASSERT_NXT(a_pkt_clear, take && item.last_byte,
                    byte_position == 16'd0 && !parse_ended && !parse_failed,
                    "packet state not cleared after last byte")
  `RMIFP_ASSERT_IMP(a_hdr_skip, parse_phase == PH_HEADER,
                    byte_position <= 16'(HEADER_BYTES), "header skip ran past header")

endmodule

`default_nettype wire

// ===== rtl/core/rtp_meta_info_field_parser.sv =====
// ----------------------------------------------------------------------------
// rtp_meta_info_field_parser
// Parses RTP meta-info fields from a byte stream and reports per packet.
// ----------------------------------------------------------------------------
// Packet bytes enter on the byte channel (byte_valid, byte_stall, byte_data),
// one word per byte, from byte zero; last_byte marks the final byte. The
// fixed header is skipped, then compressed and uncompressed fields are parsed.
// One result word leaves on the result channel (result_valid, result_stall,
// result_data) for each packet, after its last byte, carrying the ok flag and
// the latest stored values.
// The block takes one byte per cycle while the input does not stall. A byte
// is registered at the input and parsed as it moves on; the result word of a
// last byte is then registered in a two-word buffer. A receiver that stalls
// holds the buffer, and only when both words are occupied does the input
// stall, and then only on a last byte.
// The six compressed IDs are written through the APB-style port at byte
// addresses 0, 4, ..., 20; only bit 7..0 of each is kept. Synchronous reset
// sets the IDs to 128 (unused), clears all parser state and stored values,
// and empties the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_meta_info_field_parser import rmifp_pkg::*; #(
  parameter int NUM_FIELD_KINDS = DEF_NUM_FIELD_KINDS,
  parameter int HEADER_BYTES    = DEF_HEADER_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  byte_valid,
  output logic                       byte_stall,
  input  wire in_t                   byte_data,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output out_t                       result_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [NUM_ID_REGS-1:0][7:0] cfg_ids;
  logic [2:0]                  reg_idx;
  logic                        reg_hit;

  in_t  byte_q;
  logic byte_q_valid;
  logic advance;
  logic buf_full;
  out_t result;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign reg_hit = (reg_idx <= REG_ID_MEDIA_DATA);
  assign prdata  = reg_hit ? {{(CFG_DATA_W-8){1'b0}}, cfg_ids[reg_idx]} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_ID_REGS; k++) begin
        cfg_ids[k] <= ID_UNUSED;
      end
    end else if (psel && penable && pwrite && reg_hit) begin
      cfg_ids[reg_idx] <= pwdata[7:0];
    end
  end

  // Input register. A byte that produces a result moves on only when the
  // result buffer has room.
  assign advance    = byte_q_valid && (!byte_q.last_byte || !buf_full);
  assign byte_stall = byte_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_q_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      byte_q_valid <= 1'b1;
    end else if (advance) begin
      byte_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      byte_q <= byte_data;
    end
  end

  rmifp_parser #(
    .NUM_FIELD_KINDS (NUM_FIELD_KINDS),
    .HEADER_BYTES    (HEADER_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (advance),
    .item    (byte_q),
    .cfg_ids (cfg_ids),
    .result  (result)
  );

  rmifp_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (advance && byte_q.last_byte),
    .din          (result),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

`default_nettype wire

// ===== tb/rtp_meta_info_field_parser_test.sv =====
// ----------------------------------------------------------------------------
// rtp_meta_info_field_parser_test
// Self-checking testbench for the RTP meta-info field parser.
// ----------------------------------------------------------------------------
// Packets are sent byte by byte. A checker class keeps its own copy of the
// parse state, the stored field values and the six compressed IDs. It works
// out the result word for every packet and compares each result field by
// field. A directed part covers compressed and uncompressed fields, length and
// bound failures, early last bytes and trailing bytes. Random packets follow
// under several ID settings and under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_meta_info_field_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmifp_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HDR_LEN = DEF_HEADER_BYTES;
  localparam logic [7:0] COMPRESSED_FLAG = 8'h80;
  localparam logic [15:0] FIELD_NAME [NUM_ID_REGS] = '{
    16'h7070, 16'h7474, 16'h6674, 16'h706E, 16'h7371, 16'h6D64
  };
  localparam logic [15:0] FIELD_LEN [8] = '{
    16'd8, 16'd8, 16'd2, 16'd8, 16'd2, 16'd0, 16'd0, 16'd0
  };

  class result_checker;
    logic [7:0]  id_reg [NUM_ID_REGS];
    logic [15:0] pos;
    phase_t      phase;
    field_t      cur;
    logic [15:0] flen;
    logic [15:0] left;
    logic [63:0] acc;
    logic [7:0]  name_hi;
    bit          ended;
    bit          failed;
    out_t        held;
    out_t        pending [$];
    int          errors;

    function new();
      foreach (id_reg[i]) id_reg[i] = ID_UNUSED;
      held = '0;
      errors = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      pos = '0;
      phase = PH_HEADER;
      cur = FK_ILLEGAL;
      flen = '0;
      left = '0;
      acc = '0;
      name_hi = '0;
      ended = 0;
      failed = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("%0t mismatch: %s", $time, msg);
    endtask

    // First register in order wins when two hold the same ID.
    function field_t id_kind(logic [6:0] id);
      for (int k = 0; k < NUM_ID_REGS; k++)
        if (id_reg[k] == {1'b0, id}) return field_t'(k);
      return FK_ILLEGAL;
    endfunction

    function field_t name_kind(logic [15:0] n);
      for (int k = 0; k < NUM_ID_REGS; k++)
        if (FIELD_NAME[k] == n) return field_t'(k);
      return FK_ILLEGAL;
    endfunction

    function void header_done(logic [31:0] vpos, logic [31:0] plen);
      logic [15:0] need;
      need = FIELD_LEN[cur];
      if ((need != 0 && need != flen) || vpos + {16'b0, flen} > plen) begin
        failed = 1;
        ended = 1;
        return;
      end
      if (cur == FK_MEDIA) begin
        held.media_offset = vpos[15:0];
        held.media_length = flen;
      end
      left = flen;
      acc = '0;
      phase = (flen == 0) ? PH_START : PH_VALUE;
    endfunction

    function void take_byte(logic [7:0] b, logic [31:0] plen);
      logic [31:0] p;
      p = {16'b0, pos};
      if (ended) return;
      if (phase == PH_HEADER) begin
        if (p < HDR_LEN) return;
        phase = PH_START;
      end
      case (phase)
        PH_START: begin
          if (p + 2 >= plen) begin
            ended = 1;
          end else if ((b & COMPRESSED_FLAG) != 0) begin
            cur = id_kind(b[6:0]);
            phase = PH_CLEN;
          end else if (p + 4 >= plen) begin
            ended = 1;
          end else begin
            name_hi = b;
            phase = PH_NAME_LO;
          end
        end
        PH_CLEN: begin
          flen = {8'b0, b};
          header_done(p + 1, plen);
        end
        PH_NAME_LO: begin
          cur = name_kind({name_hi, b});
          phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          flen = {b, 8'b0};
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          flen[7:0] = b;
          header_done(p + 1, plen);
        end
        PH_VALUE: begin
          acc = {acc[55:0], b};
          if (left > 0) left--;
          if (left == 0) begin
            case (cur)
              FK_POSITION:   held.packet_position = acc;
              FK_XMIT_TIME:  held.transmit_time = acc;
              FK_FRAME_TYPE: held.frame_type = acc[15:0];
              FK_PACKET_NUM: held.packet_number = acc;
              FK_SEQUENCE:   held.sequence_number = acc[15:0];
              default: ;
            endcase
            phase = PH_START;
          end
        end
        default: ended = 1;
      endcase
    endfunction

    function void note_byte(in_t w);
      out_t r;
      take_byte(w.data_byte, {16'b0, w.packet_length});
      if (pos != 16'hFFFF) pos++;
      if (w.last_byte) begin
        r = held;
        r.packet_ok = !failed;
        pending.push_back(r);
        clear_packet();
      end
    endfunction

    task compare_field(string fname, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("%s got %h expected %h", fname, got, want));
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report("result word with no packet pending");
        return;
      end
      want = pending.pop_front();
      compare_field("packet_ok", got.packet_ok, want.packet_ok);
      compare_field("packet_position", got.packet_position, want.packet_position);
      compare_field("transmit_time", got.transmit_time, want.transmit_time);
      compare_field("frame_type", got.frame_type, want.frame_type);
      compare_field("packet_number", got.packet_number, want.packet_number);
      compare_field("sequence_number", got.sequence_number, want.sequence_number);
      compare_field("media_offset", got.media_offset, want.media_offset);
      compare_field("media_length", got.media_length, want.media_length);
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  byte_valid = 1'b0;
  logic                  byte_stall;
  in_t                   byte_data = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  out_t                  result_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  result_checker sb = new();
  logic [7:0] pkt [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet = 0;

  rtp_meta_info_field_parser dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result_data);
  end

  // Counts cycles in which no word, result or register access moves.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall) || psel) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(int idx, logic [7:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * idx);
    pwdata <= {24'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.id_reg[idx] = v;
  endtask

  task automatic read_reg(int idx);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CFG_ADDR_W'(4 * idx);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== sb.id_reg[idx])
      sb.report($sformatf("register %0d reads %h expected %h", idx, prdata[7:0],
                          sb.id_reg[idx]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_word(in_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= w;
    do @(posedge clk); while (byte_stall);
    sb.note_byte(w);
  endtask

  // With vary set, packet_length wanders from byte to byte.
  task automatic send_packet(int plen, bit vary);
    in_t w;
    for (int i = 0; i < pkt.size(); i++) begin
      w.data_byte = pkt[i];
      w.packet_length = (vary && $urandom_range(2) == 0) ?
                        16'($urandom_range(0, plen + 8)) : 16'(plen);
      w.last_byte = (i == pkt.size() - 1);
      send_word(w);
    end
    pkt.delete();
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  function automatic void push_header();
    repeat (HDR_LEN) pkt.push_back(8'($urandom));
  endfunction

  function automatic void push_cfield(logic [6:0] id, int len, int nval);
    pkt.push_back(COMPRESSED_FLAG | {1'b0, id});
    pkt.push_back(8'(len));
    repeat (nval) pkt.push_back(8'($urandom));
  endfunction

  function automatic void push_ufield(logic [15:0] name, int len, int nval);
    logic [15:0] l;
    l = 16'(len);
    pkt.push_back(name[15:8]);
    pkt.push_back(name[7:0]);
    pkt.push_back(l[15:8]);
    pkt.push_back(l[7:0]);
    repeat (nval) pkt.push_back(8'($urandom));
  endfunction

  task automatic random_packet(output int plen, output bit vary);
    int style, nf, k, len, nval, cut;
    logic [15:0] name;
    style = $urandom_range(99);
    vary = ($urandom_range(99) < 4);
    if (style < 10) begin
      nf = $urandom_range(1, 40);
      repeat (nf) pkt.push_back(8'($urandom));
      plen = $urandom_range(1) ? nf : $urandom_range(0, 65535);
      return;
    end
    push_header();
    nf = $urandom_range(0, 5);
    repeat (nf) begin
      k = $urandom_range(0, NUM_ID_REGS);
      len = (k < NUM_ID_REGS - 1) ? FIELD_LEN[k] : $urandom_range(0, 12);
      if ($urandom_range(99) < 8) len = $urandom_range(0, 10);
      nval = len;
      if ($urandom_range(1)) begin
        if (k < NUM_ID_REGS && sb.id_reg[k] < ID_UNUSED) push_cfield(sb.id_reg[k][6:0], len, nval);
        else push_cfield(7'($urandom), len, nval);
      end else begin
        name = (k < NUM_ID_REGS) ? FIELD_NAME[k] : {1'b0, 15'($urandom)};
        if ($urandom_range(99) < 4) begin
          len = $urandom_range(0, 65535);
          nval = 4;
        end
        push_ufield(name, len, nval);
      end
    end
    if ($urandom_range(99) < 10) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
    plen = pkt.size();
    cut = $urandom_range(99);
    if (cut < 10) plen = plen - $urandom_range(1, 6);
    else if (cut < 15) plen = plen + $urandom_range(1, 40);
    else if (cut < 23) repeat ($urandom_range(1, 4)) void'(pkt.pop_back());
  endtask

  task automatic set_ids(int seg);
    logic [7:0] extremes [NUM_ID_REGS] = '{8'd127, 8'd0, 8'd127, 8'd128, 8'd255, 8'd1};
    logic [7:0] v [NUM_ID_REGS];
    int r;
    for (int i = 0; i < NUM_ID_REGS; i++) begin
      r = $urandom_range(99);
      if (seg == 1) v[i] = extremes[i];
      else if (seg == 3) v[i] = ID_UNUSED;
      else if (r < 12) v[i] = 8'($urandom_range(128, 255));
      else if (r < 22 && i > 0) v[i] = v[$urandom_range(0, i - 1)];
      else v[i] = 8'($urandom_range(0, 127));
      write_reg(i, v[i]);
    end
    for (int i = 0; i < NUM_ID_REGS; i++) read_reg(i);
  endtask

  task automatic run_segment(int seg, int budget);
    int sent, plen;
    bit vary;
    set_ids(seg);
    sent = 0;
    while (sent < budget) begin
      random_packet(plen, vary);
      sent += pkt.size();
      send_packet(plen, vary);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_ID_REGS; i++) read_reg(i);

    // With the reset IDs no compressed field is recognized.
    push_header();
    push_cfield(7'h00, 8, 8);
    push_ufield(FIELD_NAME[FK_POSITION], 8, 8);
    send_packet(pkt.size(), 0);
    drain();

    write_reg(REG_ID_PACKET_POSITION, 8'd0);
    write_reg(REG_ID_TRANSMIT_TIME, 8'd127);
    write_reg(REG_ID_FRAME_TYPE, 8'd5);
    write_reg(REG_ID_PACKET_NUMBER, 8'h45);
    write_reg(REG_ID_SEQUENCE_NUMBER, 8'd100);
    write_reg(REG_ID_MEDIA_DATA, 8'd33);

    // Every kind in compressed form, then a zero-length media field.
    push_header();
    push_cfield(7'd0, 8, 8);
    push_cfield(7'd127, 8, 8);
    push_cfield(7'd5, 2, 2);
    push_cfield(7'h45, 8, 8);
    push_cfield(7'd100, 2, 2);
    push_cfield(7'd33, 3, 3);
    push_cfield(7'd33, 0, 0);
    send_packet(pkt.size(), 0);

    // Uncompressed forms, an unknown name, then a frame type of wrong length.
    push_header();
    push_ufield(FIELD_NAME[FK_XMIT_TIME], 8, 8);
    push_ufield(FIELD_NAME[FK_MEDIA], 0, 0);
    push_ufield(16'h0000, 2, 2);
    push_ufield(FIELD_NAME[FK_FRAME_TYPE], 3, 3);
    pkt.push_back(8'hFF);
    send_packet(pkt.size(), 0);

    // Media value that runs past the packet length.
    push_header();
    push_cfield(7'd33, 10, 5);
    send_packet(pkt.size(), 0);

    // Last byte arrives in the middle of a packet number value.
    push_header();
    push_cfield(7'h45, 8, 4);
    send_packet(pkt.size() + 4, 0);

    // A field start too near the end; the bytes after it are ignored.
    push_header();
    push_ufield(FIELD_NAME[FK_SEQUENCE], 2, 2);
    pkt.push_back(8'h12);
    pkt.push_back(8'h34);
    pkt.push_back(8'h56);
    send_packet(pkt.size() - 1, 0);

    pkt.push_back(8'hFF);
    send_packet(0, 0);

    // Room for a compressed header but not an uncompressed one.
    push_header();
    pkt.push_back(8'h00);
    pkt.push_back(8'h01);
    send_packet(16, 0);

    repeat (HDR_LEN - 1) pkt.push_back(8'hFF);
    pkt.push_back(8'h00);
    send_packet(65535, 0);
    drain();

    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 17 : (seg < 4) ? 45 : 0;
      stall_pct = (seg < 2) ? 45 : (seg < 4) ? 17 : 0;
      run_segment(seg, 225);
      drain();
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
